// ----- design/msc_pkg.sv -----
`default_nettype none

package msc_pkg;

    // Field and datapath widths
    localparam int AXIS_W  = 24;
    localparam int FIELD_W = 32;
    localparam int CC_W    = 16;
    localparam int GAIN_W  = 31;
    localparam int NUM_W   = 48;
    localparam int QUO_W   = 32;
    localparam int SQ_W    = 47;
    localparam int SUM_W   = 48;
    localparam int RAD_W   = 64;
    localparam int ROOT_W  = 32;

    // Pipeline stage counts (one quotient bit / one root bit per stage)
    localparam int DIV_LAT  = QUO_W;
    localparam int SQRT_LAT = ROOT_W;

    // Gain in Q16: slope * cycle_count + offset
    localparam logic [14:0]       GAIN_SLOPE        = 15'd24059;
    localparam logic [GAIN_W-1:0] GAIN_OFFSET       = 31'd98304;
    localparam logic [CC_W-1:0]   CYCLE_COUNT_RESET = 16'd200;
    localparam logic [GAIN_W-1:0] GAIN_RESET        = 31'd4910104;

    // Register indexes
    localparam logic [0:0] REG_CYCLE_COUNT = 1'b0;

    typedef struct packed {
        logic [AXIS_W-1:0] raw_x;
        logic [AXIS_W-1:0] raw_y;
        logic [AXIS_W-1:0] raw_z;
    } sample_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] field_x;
        logic signed [FIELD_W-1:0] field_y;
        logic signed [FIELD_W-1:0] field_z;
        logic [FIELD_W-1:0]        field_magnitude;
    } result_t;

endpackage

`default_nettype wire

// ----- design/msc_div.sv -----
`default_nettype none

module msc_div (
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic [msc_pkg::NUM_W-1:0]  num,
    input  wire logic [msc_pkg::GAIN_W-1:0] den,
    output logic      [msc_pkg::QUO_W-1:0]  quo,
    output logic                            rem_nz
);
    import msc_pkg::*;

    logic [NUM_W-1:0] rem_reg [DIV_LAT];
    logic [QUO_W-1:0] quo_reg [DIV_LAT];

    // One restoring step per stage, most significant quotient bit first
    for (genvar s = 0; s < DIV_LAT; s++) begin : g_stage
        localparam int B = QUO_W - 1 - s;
        logic [NUM_W-1:0] rem_in;
        logic [QUO_W-1:0] quo_in;
        logic [63:0]      trial;
        logic             fit;

        if (s == 0) begin : g_first
            assign rem_in = num;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = rem_reg[s-1];
            assign quo_in = quo_reg[s-1];
        end

        assign trial = {{(64-GAIN_W){1'b0}}, den} << B;
        assign fit   = {{(64-NUM_W){1'b0}}, rem_in} >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= fit ? rem_in - trial[NUM_W-1:0] : rem_in;
                quo_reg[s] <= quo_in | (fit ? (QUO_W'(1) << B) : '0);
            end
        end
    end

    assign quo    = quo_reg[DIV_LAT-1];
    assign rem_nz = |rem_reg[DIV_LAT-1];

endmodule

`default_nettype wire

// ----- design/msc_isqrt.sv -----
`default_nettype none

module msc_isqrt (
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic [msc_pkg::RAD_W-1:0]  rad,
    output logic      [msc_pkg::ROOT_W-1:0] root
);
    import msc_pkg::*;

    logic [RAD_W-1:0] v_reg   [SQRT_LAT];
    logic [RAD_W-1:0] res_reg [SQRT_LAT];

    // One root bit per stage, bit weight falls by a factor of four each stage
    for (genvar s = 0; s < SQRT_LAT; s++) begin : g_stage
        localparam int P = RAD_W - 2 - 2 * s;
        logic [RAD_W-1:0] v_in;
        logic [RAD_W-1:0] res_in;
        logic [RAD_W-1:0] bitw;
        logic [RAD_W-1:0] trial;
        logic             fit;

        if (s == 0) begin : g_first
            assign v_in   = rad;
            assign res_in = '0;
        end else begin : g_next
            assign v_in   = v_reg[s-1];
            assign res_in = res_reg[s-1];
        end

        assign bitw  = RAD_W'(1) << P;
        assign trial = res_in + bitw;
        assign fit   = v_in >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[s]   <= fit ? v_in - trial : v_in;
                res_reg[s] <= fit ? (res_in >> 1) + bitw : res_in >> 1;
            end
        end
    end

    assign root = res_reg[SQRT_LAT-1][ROOT_W-1:0];

endmodule

`default_nettype wire

// ----- design/msc_lane.sv -----
`default_nettype none

module msc_lane (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic [msc_pkg::AXIS_W-1:0]  raw,
    input  wire logic [msc_pkg::GAIN_W-1:0]  gain,
    output logic      [msc_pkg::SQ_W-1:0]    sq,
    output logic signed [msc_pkg::FIELD_W-1:0] field
);
    import msc_pkg::*;

    logic [AXIS_W-1:0]   mag;
    logic [2*AXIS_W-1:0] prod;
    logic [AXIS_W-1:0]   mag_reg;
    logic                neg_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic                neg_dly_reg [DIV_LAT];
    logic [QUO_W-1:0]    quo;
    logic                rem_nz;
    logic [FIELD_W-1:0]  ceil_q;
    logic [FIELD_W-1:0]  field_reg;

    // Split the count into sign and magnitude, square the magnitude
    assign mag  = raw[AXIS_W-1] ? ~raw + AXIS_W'(1) : raw;
    assign prod = mag * mag;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= mag;
            neg_reg <= raw[AXIS_W-1];
            sq_reg  <= prod[SQ_W-1:0];
        end
    end

    msc_div u_div (
        .clk    (clk),
        .en     (en),
        .num    ({mag_reg, {(NUM_W-AXIS_W){1'b0}}}),
        .den    (gain),
        .quo    (quo),
        .rem_nz (rem_nz)
    );

    // Carry the sign alongside the divider
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_dly_reg[0] <= neg_reg;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                neg_dly_reg[i] <= neg_dly_reg[i-1];
            end
        end
    end

    // Negative counts round toward minus infinity: negate the ceiling
    assign ceil_q = quo + FIELD_W'(rem_nz);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            field_reg <= neg_dly_reg[DIV_LAT-1] ? FIELD_W'(0) - ceil_q : quo;
        end
    end

    assign sq    = sq_reg;
    assign field = signed'(field_reg);

endmodule

`default_nettype wire

// ----- design/magnetometer_sample_scaler_unit.sv -----
`default_nettype none

// Channel   Dir  Signals                                   Payload
// sample    in   sample_valid / sample_ready               raw_x, raw_y, raw_z
// result    out  result_valid / result_ready               field_x/y/z, field_magnitude
// config    in   psel, penable, pwrite, paddr, pwdata      cycle_count (addr 0)
//
// One request per cycle while the pipeline is not held; the path runs through the 32-stage
// square root followed by the 32-stage magnitude divider (axis lanes wait in a delay line).
// Reset clears the pipeline valid bits and loads cycle_count = 200.
// A result not taken holds the whole pipeline; sample_ready then drops.

module magnetometer_sample_scaler_unit (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             sample_valid,
    output logic                  sample_ready,
    input  wire msc_pkg::sample_t sample,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output msc_pkg::result_t      result,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import msc_pkg::*;

    localparam int PIPE_DEPTH = 3 + SQRT_LAT + DIV_LAT;
    localparam int AXIS_DLY   = SQRT_LAT;

    logic [CC_W-1:0]       cycle_count_reg;
    logic [GAIN_W-1:0]     gain_reg;
    logic [GAIN_W-1:0]     gain_next;
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic                  adv;
    logic                  addr_hit;
    logic [SQ_W-1:0]       sq_x, sq_y, sq_z;
    logic signed [FIELD_W-1:0] fx, fy, fz;
    logic [SUM_W-1:0]      sum_reg;
    logic [ROOT_W-1:0]     root;
    logic [QUO_W-1:0]      mag_quo;
    logic                  mag_rem_nz;
    logic [FIELD_W-1:0]    dx_reg [AXIS_DLY];
    logic [FIELD_W-1:0]    dy_reg [AXIS_DLY];
    logic [FIELD_W-1:0]    dz_reg [AXIS_DLY];
    result_t               result_reg;

    // Configuration port
    assign pready   = 1'b1;
    assign addr_hit = (paddr[2] == REG_CYCLE_COUNT) && (paddr[1:0] == 2'b00);
    assign prdata   = addr_hit ? {{(32-CC_W){1'b0}}, cycle_count_reg} : 32'd0;
    assign gain_next = GAIN_W'(GAIN_SLOPE) * GAIN_W'(cycle_count_reg) + GAIN_OFFSET;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_count_reg <= CYCLE_COUNT_RESET;
            gain_reg        <= GAIN_RESET;
        end
        else
        begin
            if (psel && penable && pwrite && addr_hit)
            begin
                cycle_count_reg <= pwdata[CC_W-1:0];
            end
            gain_reg <= gain_next;
        end
    end

    // Advance the whole pipeline unless the result is held
    assign adv          = !valid_reg[PIPE_DEPTH-1] || result_ready;
    assign sample_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], sample_valid};
        end
    end

    // Axis lanes
    msc_lane u_lane_x (.clk(clk), .en(adv), .raw(sample.raw_x), .gain(gain_reg),
                       .sq(sq_x), .field(fx));
    msc_lane u_lane_y (.clk(clk), .en(adv), .raw(sample.raw_y), .gain(gain_reg),
                       .sq(sq_y), .field(fy));
    msc_lane u_lane_z (.clk(clk), .en(adv), .raw(sample.raw_z), .gain(gain_reg),
                       .sq(sq_z), .field(fz));

    // Merge: sum of squares, root, magnitude divide
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum_reg <= SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
        end
    end

    msc_isqrt u_isqrt (
        .clk  (clk),
        .en   (adv),
        .rad  ({sum_reg, {(RAD_W-SUM_W){1'b0}}}),
        .root (root)
    );

    msc_div u_mag_div (
        .clk    (clk),
        .en     (adv),
        .num    ({root, {(NUM_W-ROOT_W){1'b0}}}),
        .den    (gain_reg),
        .quo    (mag_quo),
        .rem_nz (mag_rem_nz)
    );

    // Delay the axis fields to meet the magnitude
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg[0] <= fx;
            dy_reg[0] <= fy;
            dz_reg[0] <= fz;
            for (int i = 1; i < AXIS_DLY; i++)
            begin
                dx_reg[i] <= dx_reg[i-1];
                dy_reg[i] <= dy_reg[i-1];
                dz_reg[i] <= dz_reg[i-1];
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg.field_x         <= signed'(dx_reg[AXIS_DLY-1]);
            result_reg.field_y         <= signed'(dy_reg[AXIS_DLY-1]);
            result_reg.field_z         <= signed'(dz_reg[AXIS_DLY-1]);
            result_reg.field_magnitude <= mag_quo;
        end
    end

    assign result_valid = valid_reg[PIPE_DEPTH-1];
    assign result       = result_reg;

    // Stalled pipeline keeps its occupancy
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(valid_reg))
        else $error("pipeline occupancy moved during stall");

    // Accepted request enters the first stage
    a_accept_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready) |=> valid_reg[0])
        else $error("accepted request lost at entry");

    // Gain never falls below its offset, so the divisor is never zero
    a_gain_floor: assert property (@(posedge clk) disable iff (!rst_n)
        gain_reg >= GAIN_OFFSET)
        else $error("gain below offset");

    // Held result blocks new requests
    a_mag_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |-> !sample_ready)
        else $error("ready while result held");

endmodule

`default_nettype wire

// ----- sim/magnetometer_sample_scaler_unit_test.sv -----
`default_nettype none

module magnetometer_sample_scaler_unit_test;
    import msc_pkg::*;

    localparam int LATENCY     = 67;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        sample_valid;
    logic        sample_ready;
    sample_t     sample;
    logic        result_valid;
    logic        result_ready;
    result_t     result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Scaler configuration as the predictor sees it
    logic [15:0] cycle_count_shadow;
    result_t     expected_fields[$];
    int          mismatch_count;
    int          request_count;
    int          result_count;
    int          cycle_count_total;
    bit          allow_idle;
    bit          hold_results;
    int          hold_cycles;

    magnetometer_sample_scaler_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Generate clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Exact floor square root of a 64-bit value, bit by bit
    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitpos;
        root   = 64'd0;
        bitpos = 64'd1 << 62;
        while (bitpos > v)
            bitpos = bitpos >> 2;
        while (bitpos != 64'd0)
        begin
            if (v >= root + bitpos)
            begin
                v    = v - (root + bitpos);
                root = (root >> 1) + bitpos;
            end
            else
                root = root >> 1;
            bitpos = bitpos >> 2;
        end
        return root;
    endfunction

    // Compute the expected field values of one sample
    function automatic result_t scale_sample(input sample_t s);
        result_t     r;
        logic [63:0] gain;
        logic [63:0] mag[3];
        logic [63:0] quo;
        logic [63:0] sumsq;
        logic [23:0] raw[3];
        logic [31:0] field[3];
        gain   = 64'd24059 * cycle_count_shadow + 64'd98304;
        raw[0] = s.raw_x;
        raw[1] = s.raw_y;
        raw[2] = s.raw_z;
        sumsq  = 64'd0;
        for (int i = 0; i < 3; i++)
        begin
            if (raw[i][23])
            begin
                mag[i]   = 64'h1000000 - raw[i];
                quo      = ((mag[i] << 24) + gain - 1) / gain;
                field[i] = 32'(64'd0 - quo);
            end
            else
            begin
                mag[i]   = raw[i];
                field[i] = 32'((mag[i] << 24) / gain);
            end
            sumsq = sumsq + mag[i] * mag[i];
        end
        r.field_x         = field[0];
        r.field_y         = field[1];
        r.field_z         = field[2];
        r.field_magnitude = 32'((floor_sqrt(sumsq << 16) << 16) / gain);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("mismatch on result %0d: %s got %h expected %h",
                 result_count, what, got, want);
    endtask

    // Cycle counter and timeout
    always @(posedge clk)
    begin
        cycle_count_total <= cycle_count_total + 1;
        if (cycle_count_total > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count_total);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Drive result_ready: random stall bursts, or a long hold when asked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            hold_cycles  <= 0;
        end
        else if (hold_results && hold_cycles < 300)
        begin
            result_ready <= 1'b0;
            hold_cycles  <= hold_cycles + 1;
        end
        else if (!allow_idle)
            result_ready <= 1'b1;
        else
            result_ready <= ($urandom_range(0, 3) != 0);
    end

    // Check each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_fields.size() == 0)
            begin
                report_mismatch("unexpected result", result.field_x, 32'd0);
            end
            else
            begin
                want = expected_fields.pop_front();
                if (result.field_x !== want.field_x)
                    report_mismatch("field_x", result.field_x, want.field_x);
                if (result.field_y !== want.field_y)
                    report_mismatch("field_y", result.field_y, want.field_y);
                if (result.field_z !== want.field_z)
                    report_mismatch("field_z", result.field_z, want.field_z);
                if (result.field_magnitude !== want.field_magnitude)
                    report_mismatch("field_magnitude", result.field_magnitude,
                                    want.field_magnitude);
            end
            result_count++;
        end
    end

    // Send one request; drop valid for an idle burst first when allowed
    task automatic send_sample(input sample_t s);
        if (allow_idle && $urandom_range(0, 3) == 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= s;
        expected_fields.push_back(scale_sample(s));
        do
            @(posedge clk);
        while (!sample_ready);
        request_count++;
    endtask

    task automatic drain_results();
        sample_valid <= 1'b0;
        while (expected_fields.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic write_cycle_count(input logic [31:0] value);
        drain_results();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * REG_CYCLE_COUNT);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cycle_count_shadow = value[15:0];
    endtask

    task automatic write_unknown_register(input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= 3'd4;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic sample_t random_sample();
        sample_t s;
        s.raw_x = 24'($urandom);
        s.raw_y = 24'($urandom);
        s.raw_z = 24'($urandom);
        // Mix in small counts and extremes
        case ($urandom_range(0, 5))
            0: s.raw_x = 24'h800000;
            1: s.raw_y = 24'($urandom_range(0, 255));
            2: s.raw_z = 24'h FFFFFF - 24'($urandom_range(0, 255));
            default: ;
        endcase
        return s;
    endfunction

    task automatic test_directed_extremes();
        logic [23:0] corner[8];
        corner = '{24'h000000, 24'h000001, 24'h7FFFFF, 24'h800000,
                   24'hFFFFFF, 24'h800001, 24'h555555, 24'hAAAAAA};
        for (int i = 0; i < 8; i++)
            send_sample('{corner[i], corner[(i + 3) % 8], corner[(i + 5) % 8]});
        send_sample('{24'h800000, 24'h800000, 24'h800000});
        send_sample('{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF});
    endtask

    task automatic test_config_settings();
        logic [31:0] settings[5];
        settings = '{32'h0000_0000, 32'h0000_FFFF, 32'hFFFF_0001, 32'h0000_0001, 32'h0000_00C8};
        foreach (settings[k])
        begin
            write_cycle_count(settings[k]);
            @(posedge clk);
            write_unknown_register(32'h0000_1234);
            send_sample('{24'h800000, 24'h7FFFFF, 24'h000001});
            repeat (40) send_sample(random_sample());
        end
    endtask

    task automatic test_backpressure();
        drain_results();
        hold_results = 1'b1;
        repeat (120) send_sample(random_sample());
        hold_results = 1'b0;
        drain_results();
    endtask

    task automatic test_random_traffic();
        for (int n = 0; n < 300; n++)
        begin
            if (n % 75 == 0)
                write_cycle_count($urandom);
            send_sample(random_sample());
        end
        allow_idle = 1'b0;
        repeat (100) send_sample(random_sample());
    endtask

    initial
    begin
        rst_n              = 1'b0;
        sample_valid       = 1'b0;
        sample             = '0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        cycle_count_shadow = 16'd200;
        mismatch_count     = 0;
        request_count      = 0;
        result_count       = 0;
        cycle_count_total  = 0;
        allow_idle         = 1'b1;
        hold_results       = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_config_settings();
        test_backpressure();
        test_random_traffic();
        drain_results();

        $display("sent %0d samples and checked %0d results over several gain settings",
                 request_count, result_count);
        $display("with directed extremes, long result stall and random idling");
        if (mismatch_count == 0 && expected_fields.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
